// ===== rtl/bltr_pkg.sv =====
// shared types and constants of the bilinear tile resampler
`timescale 1ns / 1ps

package bltr_pkg;

    // request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // fixed point
    localparam int FRAC_BITS  = 16;
    localparam int REMAP_FRAC = 12;
    localparam int CHAN_MAX   = 255;

    // register reset values
    localparam logic [8:0]  SIZE_RESET       = 9'd1;
    localparam logic [2:0]  MODE_RESET       = 3'd0;
    localparam logic [31:0] FALLBACK_RESET   = 32'hFFFF_FFFF;
    localparam logic [63:0] REMAP_LOW_RESET  = 64'h0;
    localparam logic [63:0] REMAP_HIGH_RESET = 64'h1000_1000_1000_1000;

    // mode bit positions
    localparam int MODE_INV_GREEN = 0;
    localparam int MODE_REMAP     = 1;
    localparam int MODE_FALLBACK  = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH   = 3'd0,
        CFG_SOURCE_HEIGHT  = 3'd1,
        CFG_TILE_WIDTH     = 3'd2,
        CFG_TILE_HEIGHT    = 3'd3,
        CFG_MODE_BITS      = 3'd4,
        CFG_FALLBACK_COLOR = 3'd5,
        CFG_REMAP_LOW      = 3'd6,
        CFG_REMAP_HIGH     = 3'd7
    } cfg_reg_t;

    // one input item as it travels down the pipe
    typedef struct packed {
        logic        req_type;
        logic [7:0]  load_x;
        logic [7:0]  load_y;
        logic [31:0] load_pixel;
        logic [7:0]  sample_x;
        logic [7:0]  sample_y;
    } item_t;

    // per stage control
    typedef struct packed {
        logic valid;
        logic sample;
    } stage_ctl_t;

    // output shaping modes
    typedef struct packed {
        logic        inv_green;
        logic        remap;
        logic        fallback;
        logic [31:0] fallback_color;
        logic [63:0] remap_low;
        logic [63:0] remap_high;
    } mode_cfg_t;

    // pick one bank word, select is {row parity, column parity}
    function automatic logic [31:0] pick_bank(input logic [3:0][31:0] banks,
                                              input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            2'd0:    r = banks[0];
            2'd1:    r = banks[1];
            2'd2:    r = banks[2];
            default: r = banks[3];
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bltr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
`timescale 1ns / 1ps

module bltr_div #(
    parameter int QB  = 24,
    parameter int DW  = 10,
    parameter int SBW = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [DW-1:0]  in_rem,
    input  logic [QB-1:0]  in_dq,
    input  logic [DW-1:0]  in_div,
    input  logic [SBW-1:0] in_sb,
    output logic           out_valid,
    output logic [QB-1:0]  out_q,
    output logic [SBW-1:0] out_sb
);

    logic           vld_reg [QB];
    logic [DW-1:0]  rem_reg [QB];
    logic [QB-1:0]  dq_reg  [QB];
    logic [DW-1:0]  div_reg [QB];
    logic [SBW-1:0] sb_reg  [QB];

    genvar k;
    for (k = 0; k < QB; k++)
    begin : g_step
        logic           vld_in;
        logic [DW-1:0]  rem_in;
        logic [QB-1:0]  dq_in;
        logic [DW-1:0]  div_in;
        logic [SBW-1:0] sb_in;
        logic [DW:0]    trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = in_rem;
            assign dq_in  = in_dq;
            assign div_in = in_div;
            assign sb_in  = in_sb;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dq_in  = dq_reg[k-1];
            assign div_in = div_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        // shift in next dividend bit and try a subtract
        assign trial = {rem_in, dq_in[QB-1]};
        assign ge    = trial >= {1'b0, div_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DW'(trial - {1'b0, div_in}) : DW'(trial);
                dq_reg[k]  <= {dq_in[QB-2:0], ge};
                div_reg[k] <= div_in;
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_q     = dq_reg[QB-1];
    assign out_sb    = sb_reg[QB-1];

endmodule

// ===== rtl/bltr_store.sv =====
// source image store in four parity banks, fetch of the 2x2 neighborhood
`timescale 1ns / 1ps

module bltr_store #(
    parameter int MAX_DIM = 256,
    parameter int IW      = 8,
    parameter int BW      = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  bltr_pkg::stage_ctl_t  in_ctl,
    input  bltr_pkg::item_t       item,
    input  logic [IW-1:0]         x0,
    input  logic [IW-1:0]         x1,
    input  logic [IW-1:0]         y0,
    input  logic [IW-1:0]         y1,
    input  logic [15:0]           fx,
    input  logic [15:0]           fy,
    output bltr_pkg::stage_ctl_t  out_ctl,
    output logic [3:0][31:0]      out_px,
    output logic [15:0]           out_fx,
    output logic [15:0]           out_fy,
    output logic [7:0]            out_dest_x,
    output logic [7:0]            out_dest_y
);

    localparam int DEPTH = 2 ** (2 * BW);

    logic [IW-1:0]     wr_x;
    logic [IW-1:0]     wr_y;
    logic              wr_en;
    logic [1:0]        wr_bank;
    logic [2*BW-1:0]   wr_addr;
    logic [31:0]       rd_data [4];
    logic [3:0][31:0]  rd_bus;

    bltr_pkg::stage_ctl_t f_ctl_reg;
    logic [3:0]           f_par_reg;
    logic [15:0]          f_fx_reg;
    logic [15:0]          f_fy_reg;
    logic [7:0]           f_dx_reg;
    logic [7:0]           f_dy_reg;

    bltr_pkg::stage_ctl_t r_ctl_reg;
    logic [3:0][31:0]     r_px_reg;
    logic [15:0]          r_fx_reg;
    logic [15:0]          r_fy_reg;
    logic [7:0]           r_dx_reg;
    logic [7:0]           r_dy_reg;

    // load write port, loads outside the store are dropped
    assign wr_x    = IW'(item.load_x);
    assign wr_y    = IW'(item.load_y);
    assign wr_en   = in_ctl.valid && (item.req_type == bltr_pkg::REQ_LOAD)
                     && (32'(item.load_x) < MAX_DIM) && (32'(item.load_y) < MAX_DIM);
    assign wr_bank = {wr_y[0], wr_x[0]};
    assign wr_addr = {BW'(wr_y >> 1), BW'(wr_x >> 1)};

    // one bank per column and row parity, each reads one word per transfer
    genvar b;
    for (b = 0; b < 4; b++)
    begin : g_bank
        localparam logic XB = 1'(b % 2);
        localparam logic YB = 1'(b / 2);
        logic [31:0]     mem [DEPTH];
        logic [IW-1:0]   col;
        logic [IW-1:0]   row;
        logic [2*BW-1:0] rd_addr;

        assign col     = (x0[0] == XB) ? x0 : x1;
        assign row     = (y0[0] == YB) ? y0 : y1;
        assign rd_addr = {BW'(row >> 1), BW'(col >> 1)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (wr_en && (wr_bank == 2'(b)))
                begin
                    mem[wr_addr] <= item.load_pixel;
                end
                rd_data[b] <= mem[rd_addr];
            end
        end

        assign rd_bus[b] = rd_data[b];
    end

    // fetch stage sideband
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_ctl_reg <= '0;
            r_ctl_reg <= '0;
        end
        else if (en)
        begin
            f_ctl_reg <= in_ctl;
            r_ctl_reg <= f_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_par_reg <= {y1[0], y0[0], x1[0], x0[0]};
            f_fx_reg  <= fx;
            f_fy_reg  <= fy;
            f_dx_reg  <= item.sample_x;
            f_dy_reg  <= item.sample_y;
        end
    end

    // route bank words to the four corners
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_px_reg[0] <= bltr_pkg::pick_bank(rd_bus, {f_par_reg[2], f_par_reg[0]});
            r_px_reg[1] <= bltr_pkg::pick_bank(rd_bus, {f_par_reg[2], f_par_reg[1]});
            r_px_reg[2] <= bltr_pkg::pick_bank(rd_bus, {f_par_reg[3], f_par_reg[0]});
            r_px_reg[3] <= bltr_pkg::pick_bank(rd_bus, {f_par_reg[3], f_par_reg[1]});
            r_fx_reg    <= f_fx_reg;
            r_fy_reg    <= f_fy_reg;
            r_dx_reg    <= f_dx_reg;
            r_dy_reg    <= f_dy_reg;
        end
    end

    assign out_ctl    = r_ctl_reg;
    assign out_px     = r_px_reg;
    assign out_fx     = r_fx_reg;
    assign out_fy     = r_fy_reg;
    assign out_dest_x = r_dx_reg;
    assign out_dest_y = r_dy_reg;

endmodule

// ===== rtl/bltr_blend.sv =====
// bilinear blend, fallback, green inversion and channel remap stages
`timescale 1ns / 1ps

module bltr_blend (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [3:0][31:0]     px,
    input  logic [15:0]          fx,
    input  logic [15:0]          fy,
    input  logic [7:0]           dest_x,
    input  logic [7:0]           dest_y,
    input  bltr_pkg::mode_cfg_t  cfg,
    output logic                 out_valid,
    output logic [7:0]           out_dest_x,
    output logic [7:0]           out_dest_y,
    output logic [3:0][7:0]      out_rgba
);

    localparam logic signed [43:0] HALF_V  = 44'sd2147483648;
    localparam logic signed [25:0] HALF_RM = 26'sd1 <<< (bltr_pkg::REMAP_FRAC - 1);

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg, b5_valid_reg;
    logic [7:0] b1_dx_reg, b2_dx_reg, b3_dx_reg, b4_dx_reg, b5_dx_reg;
    logic [7:0] b1_dy_reg, b2_dy_reg, b3_dy_reg, b4_dy_reg, b5_dy_reg;
    logic [15:0] b1_fy_reg;

    logic signed [25:0] b1_top_next [4];
    logic signed [25:0] b1_bot_next [4];
    logic signed [25:0] b1_top_reg  [4];
    logic signed [25:0] b1_bot_reg  [4];
    logic signed [43:0] b2_v_next   [4];
    logic signed [43:0] b2_v_reg    [4];
    logic [7:0]         b3_ch_next  [4];
    logic [7:0]         b3_ch_reg   [4];
    logic signed [25:0] b4_n_next   [4];
    logic signed [25:0] b4_n_reg    [4];
    logic [7:0]         b4_ch_reg   [4];
    logic [7:0]         b5_ch_next  [4];
    logic [3:0][7:0]    b5_ch_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
        end
    end

    // horizontal blend of top and bottom rows
    always_comb
    begin
        logic signed [16:0] fxs;
        logic signed [8:0]  dt;
        logic signed [8:0]  db;
        logic signed [25:0] pt;
        logic signed [25:0] pb;
        logic [7:0]         a, bb, e, g;
        fxs = $signed({1'b0, fx});
        for (int c = 0; c < 4; c++)
        begin
            a  = px[0][8*c +: 8];
            bb = px[1][8*c +: 8];
            e  = px[2][8*c +: 8];
            g  = px[3][8*c +: 8];
            dt = $signed({1'b0, bb} - {1'b0, a});
            db = $signed({1'b0, g} - {1'b0, e});
            pt = fxs * dt;
            pb = fxs * db;
            b1_top_next[c] = $signed({2'b00, a, 16'h0000}) + pt;
            b1_bot_next[c] = $signed({2'b00, e, 16'h0000}) + pb;
        end
    end

    // vertical blend
    always_comb
    begin
        logic signed [16:0] fys;
        logic signed [26:0] dv;
        logic signed [43:0] pv;
        logic signed [43:0] base;
        fys = $signed({1'b0, b1_fy_reg});
        for (int c = 0; c < 4; c++)
        begin
            dv   = 27'(b1_bot_reg[c]) - 27'(b1_top_reg[c]);
            pv   = fys * dv;
            base = $signed({b1_top_reg[c], 16'h0000});
            b2_v_next[c] = base + pv;
        end
    end

    // round half up, clamp, fallback color and green inversion
    always_comb
    begin
        logic signed [43:0] s;
        logic [11:0]        r;
        logic [7:0]         ch;
        for (int c = 0; c < 4; c++)
        begin
            s = b2_v_reg[c] + HALF_V;
            r = s[43:32];
            if (b2_v_reg[c] < 0)
            begin
                ch = 8'd0;
            end
            else if (r > 12'(bltr_pkg::CHAN_MAX))
            begin
                ch = 8'(bltr_pkg::CHAN_MAX);
            end
            else
            begin
                ch = r[7:0];
            end
            if (cfg.fallback)
            begin
                ch = cfg.fallback_color[8*c +: 8];
            end
            if (cfg.inv_green && (c == 1))
            begin
                ch = 8'(bltr_pkg::CHAN_MAX) - ch;
            end
            b3_ch_next[c] = ch;
        end
    end

    // remap products
    always_comb
    begin
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [24:0] pl;
        logic signed [24:0] ph;
        for (int c = 0; c < 4; c++)
        begin
            lo = $signed(cfg.remap_low[16*c +: 16]);
            hi = $signed(cfg.remap_high[16*c +: 16]);
            pl = lo * $signed({1'b0, 8'(bltr_pkg::CHAN_MAX) - b3_ch_reg[c]});
            ph = hi * $signed({1'b0, b3_ch_reg[c]});
            b4_n_next[c] = 26'(pl) + 26'(ph);
        end
    end

    // remap rounding and clamp
    always_comb
    begin
        logic signed [25:0] s;
        logic [13:0]        r;
        for (int c = 0; c < 4; c++)
        begin
            s = b4_n_reg[c] + HALF_RM;
            r = 14'(s >>> bltr_pkg::REMAP_FRAC);
            if (!cfg.remap)
            begin
                b5_ch_next[c] = b4_ch_reg[c];
            end
            else if (b4_n_reg[c] <= 0)
            begin
                b5_ch_next[c] = 8'd0;
            end
            else if (r > 14'(bltr_pkg::CHAN_MAX))
            begin
                b5_ch_next[c] = 8'(bltr_pkg::CHAN_MAX);
            end
            else
            begin
                b5_ch_next[c] = r[7:0];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                b1_top_reg[c] <= b1_top_next[c];
                b1_bot_reg[c] <= b1_bot_next[c];
                b2_v_reg[c]   <= b2_v_next[c];
                b3_ch_reg[c]  <= b3_ch_next[c];
                b4_n_reg[c]   <= b4_n_next[c];
                b4_ch_reg[c]  <= b3_ch_reg[c];
                b5_ch_reg[c]  <= b5_ch_next[c];
            end
            b1_fy_reg <= fy;
            b1_dx_reg <= dest_x;
            b1_dy_reg <= dest_y;
            b2_dx_reg <= b1_dx_reg;
            b2_dy_reg <= b1_dy_reg;
            b3_dx_reg <= b2_dx_reg;
            b3_dy_reg <= b2_dy_reg;
            b4_dx_reg <= b3_dx_reg;
            b4_dy_reg <= b3_dy_reg;
            b5_dx_reg <= b4_dx_reg;
            b5_dy_reg <= b4_dy_reg;
        end
    end

    assign out_valid  = b5_valid_reg;
    assign out_dest_x = b5_dx_reg;
    assign out_dest_y = b5_dy_reg;
    assign out_rgba   = b5_ch_reg;

endmodule

// ===== rtl/bilinear_tile_resample.sv =====
// Bilinear tile resampler over a four-bank RGBA source store.
// Input channel (in_valid / in_stall): req_type 0 writes load_pixel at
// (load_x, load_y); req_type 1 asks for tile pixel (sample_x, sample_y).
// Output channel (out_valid / out_stall): one RGBA result per sample, in
// order, with dest_x / dest_y echoing the tile pixel; loads give nothing.
// Config channel (cfg_valid / cfg_ready): cfg_index selects the register,
// cfg_data holds the value; write only while the pipe is empty.
// One transfer per cycle is sustained while the output is not stalled. A
// sample passes the input and product registers, the axis dividers (one
// quotient bit per stage), the fetch and route registers and the blend
// stages before its result is presented.
// Loads are written at the fetch stage, so a sample always sees exactly
// the loads that came before it.
// A stalled output freezes the whole pipe and raises in_stall in the same
// cycle; nothing is lost or repeated.
// Reset empties the pipe and returns all registers to defaults; the source
// store itself is not cleared, an unwritten pixel reads back as junk.
`timescale 1ns / 1ps

module bilinear_tile_resample #(
    parameter int MAX_DIM = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  load_x,
    input  logic [7:0]  load_y,
    input  logic [31:0] load_pixel,
    input  logic [7:0]  sample_x,
    input  logic [7:0]  sample_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  dest_x,
    output logic [7:0]  dest_y,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int BW    = (IW > 1) ? IW - 1 : 1;
    localparam int SW    = $clog2(MAX_DIM + 1);
    localparam int DW    = SW + 1;
    localparam int PW    = 9 + SW;
    localparam int LW    = 2 * SW + 1;
    localparam int QB    = IW + bltr_pkg::FRAC_BITS;
    localparam int SBY   = 1 + IW;
    localparam int SBX   = SBY + $bits(bltr_pkg::item_t);

    // configuration registers
    logic [8:0]  source_width_reg, source_height_reg;
    logic [8:0]  tile_width_reg, tile_height_reg;
    logic [2:0]  mode_bits_reg;
    logic [31:0] fallback_color_reg;
    logic [63:0] remap_low_reg, remap_high_reg;
    logic [SW-1:0] sw_eff_reg, sh_eff_reg, tw_eff_reg, th_eff_reg;

    logic en;

    // front stages
    logic            s0_valid_reg;
    bltr_pkg::item_t s0_item_reg;
    logic            s1_valid_reg;
    bltr_pkg::item_t s1_item_reg;
    logic [PW-1:0]   s1_px_reg, s1_py_reg;
    logic [LW-1:0]   s1_lx_reg, s1_ly_reg;
    logic [SW-1:0]   s1_tx_reg, s1_ty_reg;
    logic [IW-1:0]   s1_mx_reg, s1_my_reg;

    logic [DW-1:0]   rem0_x, rem0_y, div_x, div_y;
    logic [QB-1:0]   dq0_x, dq0_y;
    logic            ovf0_x, ovf0_y;

    // divider outputs
    logic            dv_valid_x, dv_valid_y;
    logic [QB-1:0]   q_x, q_y;
    logic [SBX-1:0]  dv_sb_x;
    logic [SBY-1:0]  dv_sb_y;
    logic            ovf_x, ovf_y;
    logic [IW-1:0]   sm1_x, sm1_y;
    bltr_pkg::item_t dv_item;
    logic [IW-1:0]   q_int_x, q_int_y;
    logic [IW-1:0]   x0, x1, y0, y1;
    logic [15:0]     fx, fy;

    bltr_pkg::stage_ctl_t st_in_ctl, st_out_ctl;
    logic [3:0][31:0]     st_px;
    logic [15:0]          st_fx, st_fy;
    logic [7:0]           st_dx, st_dy;
    bltr_pkg::mode_cfg_t  mode_cfg;
    logic [3:0][7:0]      rgba;

    function automatic logic [SW-1:0] eff_dim(input logic [8:0] v);
        logic [SW-1:0] r;
        if (v == 9'd0)
        begin
            r = SW'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            r = SW'(MAX_DIM);
        end
        else
        begin
            r = SW'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg   <= bltr_pkg::SIZE_RESET;
            source_height_reg  <= bltr_pkg::SIZE_RESET;
            tile_width_reg     <= bltr_pkg::SIZE_RESET;
            tile_height_reg    <= bltr_pkg::SIZE_RESET;
            mode_bits_reg      <= bltr_pkg::MODE_RESET;
            fallback_color_reg <= bltr_pkg::FALLBACK_RESET;
            remap_low_reg      <= bltr_pkg::REMAP_LOW_RESET;
            remap_high_reg     <= bltr_pkg::REMAP_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bltr_pkg::cfg_reg_t'(cfg_index))
                bltr_pkg::CFG_SOURCE_WIDTH:   source_width_reg   <= cfg_data[8:0];
                bltr_pkg::CFG_SOURCE_HEIGHT:  source_height_reg  <= cfg_data[8:0];
                bltr_pkg::CFG_TILE_WIDTH:     tile_width_reg     <= cfg_data[8:0];
                bltr_pkg::CFG_TILE_HEIGHT:    tile_height_reg    <= cfg_data[8:0];
                bltr_pkg::CFG_MODE_BITS:      mode_bits_reg      <= cfg_data[2:0];
                bltr_pkg::CFG_FALLBACK_COLOR: fallback_color_reg <= cfg_data[31:0];
                bltr_pkg::CFG_REMAP_LOW:      remap_low_reg      <= cfg_data;
                bltr_pkg::CFG_REMAP_HIGH:     remap_high_reg     <= cfg_data;
                default:                      source_width_reg   <= source_width_reg;
            endcase
        end
    end

    // clamped sizes, registered from the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_eff_reg <= SW'(1);
            sh_eff_reg <= SW'(1);
            tw_eff_reg <= SW'(1);
            th_eff_reg <= SW'(1);
        end
        else
        begin
            sw_eff_reg <= eff_dim(source_width_reg);
            sh_eff_reg <= eff_dim(source_height_reg);
            tw_eff_reg <= eff_dim(tile_width_reg);
            th_eff_reg <= eff_dim(tile_height_reg);
        end
    end

    // whole pipe advances unless a result is held at the output
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    // input register and axis products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= '{req_type: req_type, load_x: load_x, load_y: load_y,
                             load_pixel: load_pixel, sample_x: sample_x,
                             sample_y: sample_y};
            s1_item_reg <= s0_item_reg;
            s1_px_reg   <= PW'({s0_item_reg.sample_x, 1'b1}) * PW'(sw_eff_reg);
            s1_py_reg   <= PW'({s0_item_reg.sample_y, 1'b1}) * PW'(sh_eff_reg);
            s1_lx_reg   <= LW'(sw_eff_reg - SW'(1)) * LW'({tw_eff_reg, 1'b0});
            s1_ly_reg   <= LW'(sh_eff_reg - SW'(1)) * LW'({th_eff_reg, 1'b0});
            s1_tx_reg   <= tw_eff_reg;
            s1_ty_reg   <= th_eff_reg;
            s1_mx_reg   <= IW'(sw_eff_reg - SW'(1));
            s1_my_reg   <= IW'(sh_eff_reg - SW'(1));
        end
    end

    // numerator, negative wrap and edge detection per axis
    always_comb
    begin
        logic          neg_x, neg_y;
        logic [PW-1:0] dif_x, dif_y, num_x, num_y;
        neg_x  = s1_px_reg < PW'(s1_tx_reg);
        neg_y  = s1_py_reg < PW'(s1_ty_reg);
        dif_x  = s1_px_reg - PW'(s1_tx_reg);
        dif_y  = s1_py_reg - PW'(s1_ty_reg);
        num_x  = neg_x ? s1_px_reg + PW'(s1_tx_reg) : dif_x;
        num_y  = neg_y ? s1_py_reg + PW'(s1_ty_reg) : dif_y;
        ovf0_x = (s1_mx_reg == '0) || (!neg_x && (32'(dif_x) >= 32'(s1_lx_reg)));
        ovf0_y = (s1_my_reg == '0) || (!neg_y && (32'(dif_y) >= 32'(s1_ly_reg)));
        rem0_x = DW'(num_x >> IW);
        rem0_y = DW'(num_y >> IW);
        dq0_x  = {IW'(num_x), 16'h0000};
        dq0_y  = {IW'(num_y), 16'h0000};
        div_x  = {s1_tx_reg, 1'b0};
        div_y  = {s1_ty_reg, 1'b0};
    end

    bltr_div #(.QB(QB), .DW(DW), .SBW(SBX)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_rem    (rem0_x),
        .in_dq     (dq0_x),
        .in_div    (div_x),
        .in_sb     ({ovf0_x, s1_mx_reg, s1_item_reg}),
        .out_valid (dv_valid_x),
        .out_q     (q_x),
        .out_sb    (dv_sb_x)
    );

    bltr_div #(.QB(QB), .DW(DW), .SBW(SBY)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_rem    (rem0_y),
        .in_dq     (dq0_y),
        .in_div    (div_y),
        .in_sb     ({ovf0_y, s1_my_reg}),
        .out_valid (dv_valid_y),
        .out_q     (q_y),
        .out_sb    (dv_sb_y)
    );

    // source indexes and fractions
    assign {ovf_x, sm1_x, dv_item} = dv_sb_x;
    assign {ovf_y, sm1_y}          = dv_sb_y;
    assign q_int_x = q_x[QB-1:bltr_pkg::FRAC_BITS];
    assign q_int_y = q_y[QB-1:bltr_pkg::FRAC_BITS];
    assign x0 = ovf_x ? sm1_x : q_int_x;
    assign x1 = ovf_x ? sm1_x : q_int_x + IW'(1);
    assign y0 = ovf_y ? sm1_y : q_int_y;
    assign y1 = ovf_y ? sm1_y : q_int_y + IW'(1);
    assign fx = ovf_x ? 16'h0000 : q_x[bltr_pkg::FRAC_BITS-1:0];
    assign fy = ovf_y ? 16'h0000 : q_y[bltr_pkg::FRAC_BITS-1:0];

    assign st_in_ctl.valid  = dv_valid_x;
    assign st_in_ctl.sample = (dv_item.req_type == bltr_pkg::REQ_SAMPLE);

    bltr_store #(.MAX_DIM(MAX_DIM), .IW(IW), .BW(BW)) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_ctl     (st_in_ctl),
        .item       (dv_item),
        .x0         (x0),
        .x1         (x1),
        .y0         (y0),
        .y1         (y1),
        .fx         (fx),
        .fy         (fy),
        .out_ctl    (st_out_ctl),
        .out_px     (st_px),
        .out_fx     (st_fx),
        .out_fy     (st_fy),
        .out_dest_x (st_dx),
        .out_dest_y (st_dy)
    );

    assign mode_cfg.inv_green      = mode_bits_reg[bltr_pkg::MODE_INV_GREEN];
    assign mode_cfg.remap          = mode_bits_reg[bltr_pkg::MODE_REMAP];
    assign mode_cfg.fallback       = mode_bits_reg[bltr_pkg::MODE_FALLBACK];
    assign mode_cfg.fallback_color = fallback_color_reg;
    assign mode_cfg.remap_low      = remap_low_reg;
    assign mode_cfg.remap_high     = remap_high_reg;

    bltr_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (st_out_ctl.valid && st_out_ctl.sample),
        .px         (st_px),
        .fx         (st_fx),
        .fy         (st_fy),
        .dest_x     (st_dx),
        .dest_y     (st_dy),
        .cfg        (mode_cfg),
        .out_valid  (out_valid),
        .out_dest_x (dest_x),
        .out_dest_y (dest_y),
        .out_rgba   (rgba)
    );

    assign red   = rgba[0];
    assign green = rgba[1];
    assign blue  = rgba[2];
    assign alpha = rgba[3];

    // both axis dividers carry the same items
    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_x == dv_valid_y)
        else $error("axis dividers out of step");

    // an unclamped column index leaves room for its right neighbor
    a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_x && !ovf_x |-> q_int_x < sm1_x)
        else $error("column index beyond source width");

    // an unclamped row index leaves room for the row below
    a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_y && !ovf_y |-> q_int_y < sm1_y)
        else $error("row index beyond source height");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the bilinear tile resampler
`timescale 1ns / 1ps

module tb_top;

    localparam int DIM = 256;
    localparam int DRAIN_CYCLES = 45;

    typedef struct packed {
        logic [7:0]       dx;
        logic [7:0]       dy;
        logic [3:0][7:0]  rgba;
    } texel_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  load_x;
    logic [7:0]  load_y;
    logic [31:0] load_pixel;
    logic [7:0]  sample_x;
    logic [7:0]  sample_y;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // shadow of the block state
    logic [31:0] image_mem [DIM*DIM];
    bit          image_set [DIM*DIM];
    logic [8:0]  src_w, src_h, tile_w, tile_h;
    logic [2:0]  mode;
    logic [31:0] fallback;
    logic [63:0] remap_lo, remap_hi;

    texel_t pending_texels[$];
    int     mismatches;
    int     loads_sent, samples_sent, texels_checked;
    bit     tx_calm, rx_calm;
    int     rx_hold;

    bilinear_tile_resample dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp_dim(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > DIM) return DIM;
        return longint'(v);
    endfunction

    // per axis source position: integer start, next, 16-bit fraction
    function automatic void map_axis(input longint c, input longint s, input longint t,
                                     output longint i0, output longint i1,
                                     output longint f);
        longint num, d, q, r;
        num = (2 * c + 1) * s - t;
        d = 2 * t;
        q = num / d;
        r = num % d;
        if (r < 0)
        begin
            r += d;
            q -= 1;
        end
        f = (r * 65536) / d;
        if (q < 0) q = 0;
        if (q > s - 1) q = s - 1;
        i0 = q;
        i1 = (q + 1 < s - 1) ? q + 1 : s - 1;
    endfunction

    function automatic logic [7:0] remap_value(input logic [7:0] v, input int c);
        longint lo, hi, n, r;
        lo = longint'($signed(remap_lo[16*c +: 16]));
        hi = longint'($signed(remap_hi[16*c +: 16]));
        n = lo * (255 - longint'(v)) + hi * longint'(v);
        if (n <= 0) return 8'd0;
        r = (n + 2048) >>> bltr_pkg::REMAP_FRAC;
        return (r > bltr_pkg::CHAN_MAX) ? 8'd255 : r[7:0];
    endfunction

    function automatic texel_t resample_texel(input logic [7:0] sx, input logic [7:0] sy);
        texel_t t;
        longint x0, x1, y0, y1, fx, fy, a, b, e, g, top, bot, v, r;
        logic [31:0] p00, p10, p01, p11;
        t.dx = sx;
        t.dy = sy;
        if (mode[bltr_pkg::MODE_FALLBACK])
        begin
            t.rgba = fallback;
        end
        else
        begin
            map_axis(longint'(sx), clamp_dim(src_w), clamp_dim(tile_w), x0, x1, fx);
            map_axis(longint'(sy), clamp_dim(src_h), clamp_dim(tile_h), y0, y1, fy);
            p00 = image_mem[y0 * DIM + x0];
            p10 = image_mem[y0 * DIM + x1];
            p01 = image_mem[y1 * DIM + x0];
            p11 = image_mem[y1 * DIM + x1];
            for (int c = 0; c < 4; c++)
            begin
                a = longint'(p00[8*c +: 8]);
                b = longint'(p10[8*c +: 8]);
                e = longint'(p01[8*c +: 8]);
                g = longint'(p11[8*c +: 8]);
                top = a * 65536 + fx * (b - a);
                bot = e * 65536 + fx * (g - e);
                v = top * 65536 + fy * (bot - top);
                r = (v < 0) ? 0 : ((v + 64'h8000_0000) >>> 32);
                t.rgba[c] = (r > bltr_pkg::CHAN_MAX) ? 8'd255 : r[7:0];
            end
        end
        if (mode[bltr_pkg::MODE_INV_GREEN]) t.rgba[1] = 8'd255 - t.rgba[1];
        if (mode[bltr_pkg::MODE_REMAP])
            for (int c = 0; c < 4; c++) t.rgba[c] = remap_value(t.rgba[c], c);
        return t;
    endfunction

    // one input transfer, optional idle cycles first
    task automatic send_item(input logic kind, input logic [7:0] lx, input logic [7:0] ly,
                             input logic [31:0] px, input logic [7:0] sx,
                             input logic [7:0] sy);
        int gap;
        gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 8);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        req_type   <= kind;
        load_x     <= lx;
        load_y     <= ly;
        load_pixel <= px;
        sample_x   <= sx;
        sample_y   <= sy;
        do @(posedge clk); while (in_stall);
        if (kind == bltr_pkg::REQ_LOAD)
        begin
            image_mem[{ly, lx}] = px;
            image_set[{ly, lx}] = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_texels.insert(pending_texels.size(), resample_texel(sx, sy));
            samples_sent++;
        end
    endtask

    task automatic load_pixel_at(input int x, input int y, input logic [31:0] px);
        send_item(bltr_pkg::REQ_LOAD, x[7:0], y[7:0], px, 8'($urandom), 8'($urandom));
    endtask

    task automatic sample_at(input int x, input int y);
        send_item(bltr_pkg::REQ_SAMPLE, 8'($urandom), 8'($urandom), $urandom, x[7:0],
                  y[7:0]);
    endtask

    // wait until every result is back and the pipe has emptied
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_texels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bltr_pkg::cfg_reg_t idx, input logic [63:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bltr_pkg::CFG_SOURCE_WIDTH:   src_w = v[8:0];
            bltr_pkg::CFG_SOURCE_HEIGHT:  src_h = v[8:0];
            bltr_pkg::CFG_TILE_WIDTH:     tile_w = v[8:0];
            bltr_pkg::CFG_TILE_HEIGHT:    tile_h = v[8:0];
            bltr_pkg::CFG_MODE_BITS:      mode = v[2:0];
            bltr_pkg::CFG_FALLBACK_COLOR: fallback = v[31:0];
            bltr_pkg::CFG_REMAP_LOW:      remap_lo = v;
            default:                      remap_hi = v;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int sw, input int sh, input int tw, input int th);
        drain();
        write_reg(bltr_pkg::CFG_SOURCE_WIDTH, 64'(sw));
        write_reg(bltr_pkg::CFG_SOURCE_HEIGHT, 64'(sh));
        write_reg(bltr_pkg::CFG_TILE_WIDTH, 64'(tw));
        write_reg(bltr_pkg::CFG_TILE_HEIGHT, 64'(th));
    endtask

    // load every pixel that the current geometry can read and that is not yet written
    task automatic fill_source();
        for (int y = 0; y < clamp_dim(src_h); y++)
            for (int x = 0; x < clamp_dim(src_w); x++)
                if (!image_set[y * DIM + x]) load_pixel_at(x, y, $urandom);
    endtask

    // random traffic: mostly samples inside the tile, some loads and samples anywhere
    task automatic random_traffic(input int n);
        int x, y;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 3)
            begin
                load_pixel_at($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                sample_at($urandom_range(0, 255), $urandom_range(0, 255));
            end
            else
            begin
                x = $urandom_range(0, int'(clamp_dim(tile_w)) - 1);
                y = $urandom_range(0, int'(clamp_dim(tile_h)) - 1);
                sample_at(x, y);
            end
        end
        tx_calm = 1'b0;
    endtask

    // directed: reset geometry and a small geometry, extreme pixels and coordinates
    task automatic test_corners();
        load_pixel_at(0, 0, 32'h0000_0000);
        sample_at(0, 0);
        load_pixel_at(0, 0, 32'hFFFF_FFFF);
        sample_at(255, 255);
        load_pixel_at(255, 255, 32'hA5A5_5A5A);
        load_pixel_at(255, 0, 32'h0102_0304);
        set_geometry(2, 2, 5, 3);
        load_pixel_at(1, 0, 32'h0000_0000);
        load_pixel_at(0, 1, 32'hFF00_FF00);
        load_pixel_at(1, 1, 32'h00FF_00FF);
        sample_at(0, 0);
        sample_at(4, 2);
        sample_at(2, 1);
        sample_at(200, 255);
    endtask

    // directed: each mode bit and the remap extremes
    task automatic test_modes();
        drain();
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(3'b001));
        sample_at(1, 1);
        drain();
        write_reg(bltr_pkg::CFG_REMAP_LOW, 64'h8000_7FFF_0000_F000);
        write_reg(bltr_pkg::CFG_REMAP_HIGH, 64'h7FFF_8000_1000_0800);
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(3'b010));
        sample_at(0, 0);
        sample_at(3, 2);
        drain();
        write_reg(bltr_pkg::CFG_FALLBACK_COLOR, 64'h80FF_0017);
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(3'b100));
        sample_at(0, 0);
        drain();
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(3'b111));
        sample_at(255, 0);
        drain();
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(bltr_pkg::MODE_RESET));
    endtask

    // random geometry, modes and remap ranges, including zero and oversize registers
    task automatic test_random_phases();
        int sizes[$] = '{0, 1, 2, 3, 5, 7, 16, 255, 256, 300, 511};
        int sw, sh, tw, th;
        logic [63:0] lo, hi;
        for (int p = 0; p < 14; p++)
        begin
            case (p)
                0: begin sw = 256; sh = 1; tw = 255; th = 1; end
                1: begin sw = 0; sh = 300; tw = 2; th = 511; end
                2: begin sw = 511; sh = 0; tw = 0; th = 3; end
                default:
                begin
                    sw = $urandom_range(1, 12);
                    sh = $urandom_range(0, 12);
                    tw = sizes[$urandom_range(0, sizes.size() - 1)];
                    th = sizes[$urandom_range(0, sizes.size() - 1)];
                end
            endcase
            set_geometry(sw, sh, tw, th);
            for (int c = 0; c < 4; c++)
            begin
                lo[16*c +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
                hi[16*c +: 16] = 16'($urandom_range(2048, 12288));
            end
            if (p % 5 == 4)
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            write_reg(bltr_pkg::CFG_REMAP_LOW, lo);
            write_reg(bltr_pkg::CFG_REMAP_HIGH, hi);
            write_reg(bltr_pkg::CFG_FALLBACK_COLOR, 64'($urandom));
            write_reg(bltr_pkg::CFG_MODE_BITS, 64'($urandom_range(0, 7)));
            fill_source();
            random_traffic(40);
        end
    endtask

    // receiver holds off while the sender keeps offering samples
    task automatic test_backpressure();
        set_geometry(6, 4, 17, 9);
        write_reg(bltr_pkg::CFG_MODE_BITS, 64'(bltr_pkg::MODE_RESET));
        fill_source();
        tx_calm = 1'b1;
        rx_hold = 300;
        for (int i = 0; i < 80; i++)
            sample_at($urandom_range(0, 16), $urandom_range(0, 8));
        tx_calm = 1'b0;
        drain();
    endtask

    // receiver stall pattern, one draw per transfer, long hold on request
    initial
    begin
        int wait_left;
        wait_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                rx_hold--;
            end
            else if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_valid && !out_stall)
                    wait_left = (rx_calm || $urandom_range(0, 2) != 0) ? 0
                                : $urandom_range(0, 8);
                if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        texel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            texels_checked++;
            if (pending_texels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t: x=%0d y=%0d", $realtime,
                             dest_x, dest_y);
            end
            else
            begin
                want = pending_texels.pop_front();
                if (want != {dest_x, dest_y, alpha, blue, green, red})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: expected x=%0d y=%0d rgba=%h",
                                 $realtime, want.dx, want.dy, want.rgba);
                        $display("    got x=%0d y=%0d rgba=%h", dest_x, dest_y,
                                 {alpha, blue, green, red});
                    end
                end
            end
        end
    end

    // timeout
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = bltr_pkg::REQ_LOAD;
        load_x = '0;
        load_y = '0;
        load_pixel = '0;
        sample_x = '0;
        sample_y = '0;
        cfg_valid = 1'b0;
        cfg_index = bltr_pkg::CFG_SOURCE_WIDTH;
        cfg_data = '0;
        rx_hold = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        mismatches = 0;
        loads_sent = 0;
        samples_sent = 0;
        texels_checked = 0;
        src_w = bltr_pkg::SIZE_RESET;
        src_h = bltr_pkg::SIZE_RESET;
        tile_w = bltr_pkg::SIZE_RESET;
        tile_h = bltr_pkg::SIZE_RESET;
        mode = bltr_pkg::MODE_RESET;
        fallback = bltr_pkg::FALLBACK_RESET;
        remap_lo = bltr_pkg::REMAP_LOW_RESET;
        remap_hi = bltr_pkg::REMAP_HIGH_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_corners();
        test_modes();
        test_backpressure();
        test_random_phases();
        drain();

        if (pending_texels.size() != 0) mismatches++;
        $display("covered %0d loads and %0d samples, %0d results checked", loads_sent,
                 samples_sent, texels_checked);
        $display("sizes ran from zero through full to oversize, with directed and random modes");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
